// File: hdl/ptt_pkg.sv
`default_nettype none
package ptt_pkg;
  localparam int NUM_ENTRIES_DEF = 16;
  localparam int ID_W = 4;
  localparam int TIME_W = 32;
  localparam int FRAC_W = 16;
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;
  localparam logic [FRAC_W-1:0] FRAC_MAX = 16'hFFFF;

  // divider request/response
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] frac;
  } div_rsp_t;
endpackage
`default_nettype wire

// File: hdl/ptt_if.sv
`default_nettype none
interface ptt_in_if;
  import ptt_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ID_W-1:0]   entry_id;
  logic [TIME_W-1:0] duration;
  logic [TIME_W-1:0] tick_us;
  modport source(output valid, operation, entry_id, duration, tick_us, input ready);
  modport sink(input valid, operation, entry_id, duration, tick_us, output ready);
endinterface

interface ptt_out_if;
  import ptt_pkg::*;
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   entry_id_res;
  logic [FRAC_W-1:0] fraction;
  logic              is_end;
  logic              last;
  modport source(output valid, entry_id_res, fraction, is_end, last, input ready);
  modport sink(input valid, entry_id_res, fraction, is_end, last, output ready);
endinterface
`default_nettype wire

// File: hdl/progress_timer_table.sv
// progress_timer_table: min(NUM_ENTRIES, 16) progress timers on a dense
// active list. operation start (re)arms an entry, cancel removes it, tick
// walks the list and emits one transaction per visited entry (end or
// progress, last on the final one). A start passes through the drop and
// append states, a cancel through the drop state only. For each visited
// entry a tick runs the table read, the divider load, 47 steps of the shared
// restoring divider, one per cycle, forming elapsed/duration in Q1.15, the
// done strobe, the output handshake (held until ready) and the list update.
// A tick ends when the table read finds no entry left or after the last slot.
// Ready is low while an operation is in progress.
`default_nettype none
module progress_timer_table
  import ptt_pkg::*;
#(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  ptt_in_if.sink   in_ch,
  ptt_out_if.source out_ch
);
  localparam int TS = (NUM_ENTRIES < 16) ? NUM_ENTRIES : 16;
  localparam int IW = (TS > 1) ? $clog2(TS) : 1;
  localparam int CW = $clog2(TS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DROP, S_APPEND, S_TREAD, S_TDIV, S_TWAIT, S_TOUT, S_TSTEP
  } state_t;

  state_t state;
  logic [TIME_W-1:0] elapsed_time [TS];
  logic [TIME_W-1:0] run_length [TS];
  logic [TS-1:0]     is_active;
  logic [IW-1:0]     list_position [TS];
  logic [IW-1:0]     active_list [TS];
  logic [CW-1:0]     active_count;

  logic [IW-1:0]     id;
  logic [TIME_W-1:0] dur;
  logic [TIME_W-1:0] ft;
  logic              do_append;
  logic [IW-1:0]     slot;
  logic [IW-1:0]     cur;
  logic [TIME_W-1:0] el;
  logic [TIME_W-1:0] rl;
  logic              ends;
  logic [TIME_W:0]   sum;
  logic [CW-1:0]     cnt_dec;
  logic [IW-1:0]     moved;

  div_req_t dreq;
  div_rsp_t drsp;

  ptt_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_ch.ready = (state == S_IDLE);
  assign sum = {1'b0, el} + {1'b0, ft};
  assign cnt_dec = active_count - 1'b1;
  assign moved = active_list[cnt_dec[IW-1:0]];

  always_comb begin
    dreq.start = (state == S_TDIV);
    dreq.num = el;
    dreq.den = rl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      is_active <= '0;
      active_count <= '0;
      out_ch.valid <= 1'b0;
      for (int i = 0; i < TS; i++) begin
        elapsed_time[i] <= '0;
        run_length[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            id <= in_ch.entry_id[IW-1:0];
            dur <= in_ch.duration;
            ft <= in_ch.tick_us;
            slot <= '0;
            if ((in_ch.operation == OP_START || in_ch.operation == OP_CANCEL) &&
                (32'(in_ch.entry_id) < TS)) begin
              do_append <= (in_ch.operation == OP_START);
              state <= S_DROP;
            end else if (in_ch.operation == OP_TICK) begin
              state <= S_TREAD;
            end
          end
        end
        S_DROP: begin
          if (is_active[id]) begin
            is_active[id] <= 1'b0;
            active_count <= cnt_dec;
            active_list[list_position[id]] <= moved;
            list_position[moved] <= list_position[id];
          end
          state <= do_append ? S_APPEND : S_IDLE;
        end
        S_APPEND: begin
          if (32'(active_count) < TS) begin
            elapsed_time[id] <= '0;
            run_length[id] <= dur;
            is_active[id] <= 1'b1;
            list_position[id] <= active_count[IW-1:0];
            active_list[active_count[IW-1:0]] <= id;
            active_count <= active_count + 1'b1;
          end
          state <= S_IDLE;
        end
        S_TREAD: begin
          if (CW'(slot) >= active_count) begin
            state <= S_IDLE;
          end else begin
            cur <= active_list[slot];
            el <= elapsed_time[active_list[slot]];
            rl <= run_length[active_list[slot]];
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          ends <= (el >= rl);
          state <= S_TWAIT;
        end
        S_TWAIT: begin
          if (drsp.done) begin
            out_ch.valid <= 1'b1;
            out_ch.entry_id_res <= ID_W'(cur);
            out_ch.fraction <= drsp.frac;
            out_ch.is_end <= ends;
            // last if no later slot remains to visit
            out_ch.last <= ends ? (CW'(slot) >= cnt_dec)
                                : (CW'(slot) + 1'b1 >= active_count);
            state <= S_TOUT;
          end
        end
        S_TOUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state <= S_TSTEP;
          end
        end
        S_TSTEP: begin
          if (ends) begin
            is_active[cur] <= 1'b0;
            active_count <= cnt_dec;
            active_list[slot] <= moved;
            list_position[moved] <= slot;
          end else begin
            elapsed_time[cur] <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            slot <= slot + 1'b1;
            if (32'(slot) == TS - 1) state <= S_IDLE;
            else state <= S_TREAD;
          end
          if (ends) state <= S_TREAD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(active_count) <= TS) else $error("active count overflow");
  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> state == S_TOUT) else $error("output valid outside output state");
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("accepting while result pending");
  a_count_pop: assert property (@(posedge clk) disable iff (rst)
    $countones(is_active) == 32'(active_count) || state != S_IDLE)
    else $error("active bits disagree with count");
endmodule
`default_nettype wire

// File: hdl/ptt_div.sv
`default_nettype none
module ptt_div
  import ptt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  // restoring divide, one quotient bit per cycle; 17 bits cover saturation
  localparam int QB = FRAC_W + 1;
  localparam int NSTEP = TIME_W + FRAC_W - 1;
  localparam int CW = $clog2(NSTEP);

  logic [TIME_W:0]   rem;
  logic [TIME_W-1:0] den;
  logic [TIME_W-1:0] num;
  logic [QB-1:0]     quo;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              zero_den;
  logic              done;
  logic [TIME_W+1:0] trial;

  always_comb begin
    // numerator is num<<15: bring in numerator bits (top first), then zeros
    trial = {rem, num[TIME_W-1]} - {2'b00, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        den <= req.den;
        num <= req.num;
        rem <= '0;
        quo <= '0;
        zero_den <= (req.den == '0);
        cnt <= CW'(NSTEP - 1);
      end else if (busy) begin
        // top quotient bit is sticky once the result passes 16 bits
        if (trial[TIME_W+1]) begin
          rem <= {rem[TIME_W-1:0], num[TIME_W-1]};
          quo <= {quo[QB-2:0], 1'b0} | {QB{quo[QB-1]}};
        end else begin
          rem <= trial[TIME_W:0];
          quo <= {quo[QB-2:0], 1'b1} | {QB{quo[QB-1]}};
        end
        num <= {num[TIME_W-2:0], 1'b0};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.frac = (zero_den || quo[QB-1]) ? FRAC_MAX : quo[FRAC_W-1:0];
  end
endmodule
`default_nettype wire
